FILE: rtl/u2u_pkg.sv
// UTF-8 to UTF-16 transcoder: shared types and constants.
// Used by the front decoder, the run queue, the unit emitter and the top level.
package u2u_pkg;

    // UTF-16 constants
    localparam logic [15:0] REPLACEMENT_UNIT = 16'hFFFD;
    localparam logic [15:0] HIGH_SURR_BASE   = 16'hD800;
    localparam logic [15:0] LOW_SURR_BASE    = 16'hDC00;
    localparam logic [20:0] SUPP_OFFSET      = 21'h010000;
    localparam logic [20:0] MAX_CODE_POINT   = 21'h10FFFF;
    localparam logic [20:0] SURR_FIRST       = 21'h00D800;
    localparam logic [20:0] SURR_LAST        = 21'h00DFFF;
    localparam logic [20:0] MIN_TWO_BYTE     = 21'h000080;
    localparam logic [20:0] MIN_THREE_BYTE   = 21'h000800;
    localparam logic [20:0] MIN_FOUR_BYTE    = 21'h010000;

    // Sequence lengths
    localparam logic [2:0] SEQ_NONE  = 3'd0;
    localparam logic [2:0] SEQ_TWO   = 3'd2;
    localparam logic [2:0] SEQ_THREE = 3'd3;
    localparam logic [2:0] SEQ_FOUR  = 3'd4;

    // What follows the replacement units of a run
    typedef enum logic [1:0] {
        TAIL_NONE = 2'd0,
        TAIL_ONE  = 2'd1,
        TAIL_PAIR = 2'd2
    } t_tail;

    // One run: rep_count replacement units, then the tail unit(s)
    typedef struct packed {
        logic [2:0]  rep_count;  // 0..4
        t_tail       tail_kind;
        logic [19:0] tail_value; // BMP unit, or code point minus 0x10000 for a pair
        logic        str_end;
    } t_run;

endpackage

FILE: rtl/u2u_front.sv
// Front part: accepts UTF-8 bytes, tracks the open sequence, classifies each byte
// into a run descriptor. Depends on u2u_pkg.
module u2u_front
    import u2u_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  logic       i_end,
    output logic       o_push,
    output t_run       o_run
);

    logic [20:0] r_pp, n_pp;
    logic [2:0]  r_exp, n_exp;
    logic [2:0]  r_taken, n_taken;

    logic        is_cont;
    logic [20:0] pp_ext;
    logic [2:0]  taken_inc;
    logic        lead_ascii;
    logic [2:0]  lead_len;
    logic [20:0] lead_pp;
    logic [20:0] min_cp;
    logic        cp_ok;
    logic [20:0] supp_cp;
    logic [2:0]  rep;
    t_tail       kind;
    logic [19:0] tail_val;

    assign is_cont   = (i_byte[7:6] == 2'b10);
    assign pp_ext    = {r_pp[14:0], i_byte[5:0]};
    assign taken_inc = r_taken + 3'd1;
    assign supp_cp   = pp_ext - SUPP_OFFSET;

    // Lead byte decode
    always_comb begin
        lead_ascii = 1'b0;
        lead_len   = SEQ_NONE;
        lead_pp    = '0;
        if (i_byte inside {[8'h00:8'h7F]}) begin
            lead_ascii = 1'b1;
        end else if (i_byte inside {[8'hC2:8'hDF]}) begin
            lead_len = SEQ_TWO;
            lead_pp  = {16'd0, i_byte[4:0]};
        end else if (i_byte inside {[8'hE0:8'hEF]}) begin
            lead_len = SEQ_THREE;
            lead_pp  = {17'd0, i_byte[3:0]};
        end else if (i_byte inside {[8'hF0:8'hF4]}) begin
            lead_len = SEQ_FOUR;
            lead_pp  = {18'd0, i_byte[2:0]};
        end
    end

    // Value check of a completed sequence
    always_comb begin
        case (r_exp)
            SEQ_TWO:   min_cp = MIN_TWO_BYTE;
            SEQ_THREE: min_cp = MIN_THREE_BYTE;
            default:   min_cp = MIN_FOUR_BYTE;
        endcase
        cp_ok = (pp_ext >= min_cp) && (pp_ext <= MAX_CODE_POINT) &&
                !((pp_ext >= SURR_FIRST) && (pp_ext <= SURR_LAST));
    end

    // Step: next sequence state and the run this byte produces
    always_comb begin
        n_pp     = r_pp;
        n_exp    = r_exp;
        n_taken  = r_taken;
        rep      = 3'd0;
        kind     = TAIL_NONE;
        tail_val = '0;
        if ((r_exp != SEQ_NONE) && is_cont) begin
            n_pp    = pp_ext;
            n_taken = taken_inc;
            if (taken_inc >= r_exp) begin
                n_pp    = '0;
                n_exp   = SEQ_NONE;
                n_taken = 3'd0;
                if (!cp_ok) begin
                    rep = taken_inc;
                end else if (pp_ext[20:16] == 5'd0) begin
                    kind     = TAIL_ONE;
                    tail_val = {4'd0, pp_ext[15:0]};
                end else begin
                    kind     = TAIL_PAIR;
                    tail_val = supp_cp[19:0];
                end
            end
        end else begin
            // broken sequence flushes its bytes, then the byte is a new lead
            if (r_exp != SEQ_NONE) begin
                rep = r_taken;
            end
            n_pp    = '0;
            n_exp   = SEQ_NONE;
            n_taken = 3'd0;
            if (lead_ascii) begin
                kind     = TAIL_ONE;
                tail_val = {12'd0, i_byte};
            end else if (lead_len != SEQ_NONE) begin
                n_pp    = lead_pp;
                n_exp   = lead_len;
                n_taken = 3'd1;
            end else begin
                rep = rep + 3'd1;
            end
        end
        // string cut off inside a sequence
        if (i_end && (n_exp != SEQ_NONE)) begin
            rep     = rep + n_taken;
            n_pp    = '0;
            n_exp   = SEQ_NONE;
            n_taken = 3'd0;
        end
    end

    assign o_push           = i_accept && ((rep != 3'd0) || (kind != TAIL_NONE));
    assign o_run.rep_count  = rep;
    assign o_run.tail_kind  = kind;
    assign o_run.tail_value = tail_val;
    assign o_run.str_end    = i_end;

    // Sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pp    <= '0;
            r_exp   <= SEQ_NONE;
            r_taken <= 3'd0;
        end else if (i_accept) begin
            r_pp    <= n_pp;
            r_exp   <= n_exp;
            r_taken <= n_taken;
        end
    end

endmodule

FILE: rtl/u2u_fifo.sv
// Two-entry run queue between the front decoder and the unit emitter.
// Depends on u2u_pkg for the run descriptor type.
module u2u_fifo
    import u2u_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_run i_run,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_run o_run
);

    t_run       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_run   = r_mem[r_rd_ptr];

    // occupancy
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_run;
        end
    end

endmodule

FILE: rtl/u2u_back.sv
// Back part: expands queued runs into UTF-16 units, one per cycle while the
// output is not stalled, into an output register. Depends on u2u_pkg.
module u2u_back
    import u2u_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_run        i_run,
    output logic        o_pop,
    input  logic        i_ready,
    output logic        o_valid,
    output logic [15:0] o_unit,
    output logic        o_last_of_run,
    output logic        o_string_done
);

    logic [1:0]  r_idx;
    logic        r_valid;
    logic [15:0] r_unit;
    logic        r_last;
    logic        r_done;

    logic        load;
    logic [2:0]  total;
    logic [2:0]  idx_ext;
    logic        is_last;
    logic [15:0] unit;

    assign load    = !i_empty && (!r_valid || i_ready);
    assign idx_ext = {1'b0, r_idx};

    // unit selection within the current run
    always_comb begin
        case (i_run.tail_kind)
            TAIL_ONE:  total = i_run.rep_count + 3'd1;
            TAIL_PAIR: total = i_run.rep_count + 3'd2;
            default:   total = i_run.rep_count;
        endcase
        is_last = (idx_ext == (total - 3'd1));
        if (idx_ext < i_run.rep_count) begin
            unit = REPLACEMENT_UNIT;
        end else if (i_run.tail_kind == TAIL_PAIR) begin
            if (idx_ext == i_run.rep_count) begin
                unit = HIGH_SURR_BASE | {6'd0, i_run.tail_value[19:10]};
            end else begin
                unit = LOW_SURR_BASE | {6'd0, i_run.tail_value[9:0]};
            end
        end else begin
            unit = i_run.tail_value[15:0];
        end
    end

    assign o_pop = load && is_last;

    // position within the run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else if (load) begin
            r_idx <= is_last ? 2'd0 : r_idx + 2'd1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_unit <= unit;
            r_last <= is_last;
            r_done <= is_last && i_run.str_end;
        end
    end

    assign o_valid       = r_valid;
    assign o_unit        = r_unit;
    assign o_last_of_run = r_last;
    assign o_string_done = r_done;

endmodule

FILE: rtl/utf8_to_utf16_transcoder_core.sv
// UTF-8 to UTF-16 transcoder, top level.
// Instantiates u2u_front, u2u_fifo and u2u_back; types from u2u_pkg.
//
// Takes one UTF-8 byte per item (tlast marks the last byte of a string) and
// gives UTF-16 code units: one per BMP code point, a surrogate pair above
// U+FFFF, and one U+FFFD per byte of a bad sequence. A byte that breaks an
// open sequence is read again as a new lead; a zero byte gives unit 0x0000.
// An input byte is taken every cycle while the two-entry run queue has room;
// the front decode of a byte is done in the cycle it is accepted. Results
// leave one unit per cycle from a registered output while m_tready is high,
// so a byte gives 0 to 4 units; on the way out a unit passes the run queue
// storage and then the output register. On the output, tuser carries
// last_of_run and tlast carries string_done.
module utf8_to_utf16_transcoder_core
    import u2u_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // string_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] code_unit
    output logic        m_tuser,   // [0] last_of_run
    output logic        m_tlast    // string_done
);

    logic accept;
    logic push;
    logic pop;
    logic full;
    logic empty;
    t_run run_in;
    t_run run_out;

    assign s_tready = !full;
    assign accept   = s_tvalid && !full;

    u2u_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_byte  (s_tdata),
        .i_end   (s_tlast),
        .o_push  (push),
        .o_run   (run_in)
    );

    u2u_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_run  (run_in),
        .i_pop  (pop),
        .o_full (full),
        .o_empty(empty),
        .o_run  (run_out)
    );

    u2u_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (empty),
        .i_run        (run_out),
        .o_pop        (pop),
        .i_ready      (m_tready),
        .o_valid      (m_tvalid),
        .o_unit       (m_tdata),
        .o_last_of_run(m_tuser),
        .o_string_done(m_tlast)
    );

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for utf8_to_utf16_transcoder_core.
// Drives UTF-8 bytes over the input stream, predicts UTF-16 units in a local decoder
// and checks every output item in order; needs only the RTL and u2u_pkg.
module tb_top;
    import u2u_pkg::*;

    localparam int ITEM_TARGET  = 480;
    localparam int TAIL_ITEMS   = 60;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 500000;

    // Lead byte classes
    localparam logic [7:0] LEAD_TWO_LO   = 8'hC2;
    localparam logic [7:0] LEAD_TWO_HI   = 8'hDF;
    localparam logic [7:0] LEAD_THREE_LO = 8'hE0;
    localparam logic [7:0] LEAD_THREE_HI = 8'hEF;
    localparam logic [7:0] LEAD_FOUR_LO  = 8'hF0;
    localparam logic [7:0] LEAD_FOUR_HI  = 8'hF4;
    localparam logic [7:0] ASCII_LIMIT   = 8'h80;
    localparam logic [1:0] CONT_TAG      = 2'b10;

    typedef logic [7:0] t_octet_q[$];

    typedef struct {
        logic [15:0] code;
        logic        run_last;
        logic        str_done;
    } t_utf16_unit;

    // Kinds of random text fragment
    typedef enum {
        FRAG_ASCII,
        FRAG_TWO,
        FRAG_THREE,
        FRAG_FOUR,
        FRAG_SURROGATE,
        FRAG_OVERLONG,
        FRAG_TOO_BIG,
        FRAG_TRUNCATED,
        FRAG_NOISE,
        FRAG_STRAY_CONT
    } t_frag_kind;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] in_byte
    logic        s_tlast;    // string_end
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [15:0] m_tdata;    // [15:0] code_unit
    logic        m_tuser;    // [0] last_of_run
    logic        m_tlast;    // string_done

    // Decoder state of the predictor
    logic [20:0] cp_acc;
    logic [2:0]  seq_len;
    logic [2:0]  seq_taken;
    logic [15:0] step_codes[$];

    t_utf16_unit expected_units[$];
    t_utf16_unit want;

    bit src_gaps_on;
    bit sink_stalls_on;
    int n_fail;
    int bytes_accepted;
    int strings_ended;
    int units_checked;
    int cycle_count = 0;

    utf8_to_utf16_transcoder_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Clock: period 12
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d units outstanding", cycle_count,
                     expected_units.size());
            $display("status: fail");
            $finish;
        end
    end

    // Output backpressure in random bursts
    always begin
        @(posedge i_clk);
        if (!i_rst_n || !sink_stalls_on || $urandom_range(0, 5) != 0) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= 1'b0;
            repeat ($urandom_range(0, 14)) @(posedge i_clk);
        end
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    // Appends one unit to the units of the current byte
    function automatic void queue_code(input logic [15:0] u);
        step_codes.insert(step_codes.size(), u);
    endfunction

    // One U+FFFD per byte of the open sequence, then close it
    function automatic void drop_sequence();
        repeat (seq_taken) queue_code(REPLACEMENT_UNIT);
        cp_acc    = '0;
        seq_len   = SEQ_NONE;
        seq_taken = '0;
    endfunction

    function automatic void open_lead(input logic [7:0] b);
        if (b < ASCII_LIMIT) begin
            queue_code({8'h00, b});
        end else if (b >= LEAD_TWO_LO && b <= LEAD_TWO_HI) begin
            seq_len = SEQ_TWO;   cp_acc = {16'd0, b[4:0]}; seq_taken = 3'd1;
        end else if (b >= LEAD_THREE_LO && b <= LEAD_THREE_HI) begin
            seq_len = SEQ_THREE; cp_acc = {17'd0, b[3:0]}; seq_taken = 3'd1;
        end else if (b >= LEAD_FOUR_LO && b <= LEAD_FOUR_HI) begin
            seq_len = SEQ_FOUR;  cp_acc = {18'd0, b[2:0]}; seq_taken = 3'd1;
        end else begin
            queue_code(REPLACEMENT_UNIT);
        end
    endfunction

    // Sequence complete: range checks, then one unit or a surrogate pair, or one U+FFFD per byte if a check fails
    function automatic void close_point();
        logic [20:0] floor_cp;
        logic [20:0] off;
        floor_cp = (seq_len == SEQ_TWO)   ? MIN_TWO_BYTE :
                   (seq_len == SEQ_THREE) ? MIN_THREE_BYTE : MIN_FOUR_BYTE;
        if (cp_acc < floor_cp || cp_acc > MAX_CODE_POINT ||
            (cp_acc >= SURR_FIRST && cp_acc <= SURR_LAST)) begin
            drop_sequence();
            return;
        end
        if (cp_acc < SUPP_OFFSET) begin
            queue_code(cp_acc[15:0]);
        end else begin
            off = cp_acc - SUPP_OFFSET;
            queue_code(HIGH_SURR_BASE + {6'd0, off[19:10]});
            queue_code(LOW_SURR_BASE + {6'd0, off[9:0]});
        end
        cp_acc    = '0;
        seq_len   = SEQ_NONE;
        seq_taken = '0;
    endfunction

    // Works out the units one accepted byte makes final and queues them
    function automatic void decode_utf8_byte(input logic [7:0] b, input logic str_end);
        int          n;
        t_utf16_unit u;
        step_codes.delete();
        if (seq_len != SEQ_NONE) begin
            if (b[7:6] == CONT_TAG) begin
                cp_acc    = {cp_acc[14:0], b[5:0]};
                seq_taken = seq_taken + 3'd1;
                if (seq_taken >= seq_len) close_point();
            end else begin
                // broken sequence: the byte is read again as a lead
                drop_sequence();
                open_lead(b);
            end
        end else begin
            open_lead(b);
        end
        // cut off at the end of the string
        if (str_end && seq_len != SEQ_NONE) drop_sequence();
        n = (step_codes.size() > 4) ? 4 : step_codes.size();
        for (int k = 0; k < n; k++) begin
            u.code     = step_codes[k];
            u.run_last = (k == n - 1);
            u.str_done = (k == n - 1) && str_end;
            expected_units.insert(expected_units.size(), u);
        end
    endfunction

    // ---------------------------------------------------------------
    // Monitor: predict on accepted input, check on accepted output
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_tvalid && s_tready) begin
                decode_utf8_byte(s_tdata, s_tlast);
                bytes_accepted++;
                if (s_tlast) strings_ended++;
            end
            if (m_tvalid && m_tready) begin
                if (expected_units.size() == 0) begin
                    $error("unexpected item: code_unit %h last_of_run %b string_done %b",
                           m_tdata, m_tuser, m_tlast);
                    n_fail++;
                end else begin
                    want = expected_units.pop_front();
                    units_checked++;
                    if (m_tdata !== want.code) begin
                        $error("code_unit: expected %h, got %h", want.code, m_tdata);
                        n_fail++;
                    end
                    if (m_tuser !== want.run_last) begin
                        $error("last_of_run: expected %b, got %b", want.run_last, m_tuser);
                        n_fail++;
                    end
                    if (m_tlast !== want.str_done) begin
                        $error("string_done: expected %b, got %b", want.str_done, m_tlast);
                        n_fail++;
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    // Sends one item, with an optional idle burst before it
    task automatic send_byte(input logic [7:0] b, input logic is_end);
        int gap;
        if (src_gaps_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 15);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= is_end;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    // Sends a run of bytes; string_end only on the last one if asked
    task automatic send_text(input t_octet_q text, input logic end_last);
        foreach (text[i]) begin
            send_byte(text[i], end_last && (i == text.size() - 1));
        end
    endtask

    // Encodes a code point in the given length, overlong forms included
    function automatic t_octet_q utf8_encode(input logic [20:0] cp, input logic [2:0] len);
        t_octet_q q;
        case (len)
            SEQ_TWO:   q = '{{3'b110, cp[10:6]}, {CONT_TAG, cp[5:0]}};
            SEQ_THREE: q = '{{4'b1110, cp[15:12]}, {CONT_TAG, cp[11:6]}, {CONT_TAG, cp[5:0]}};
            SEQ_FOUR:  q = '{{5'b11110, cp[20:18]}, {CONT_TAG, cp[17:12]},
                             {CONT_TAG, cp[11:6]}, {CONT_TAG, cp[5:0]}};
            default:   q = '{{1'b0, cp[6:0]}};
        endcase
        return q;
    endfunction

    // One random fragment: mostly well-formed characters, some broken input
    task automatic send_random_fragment();
        int          roll;
        int          cut;
        t_frag_kind  kind;
        logic [2:0]  len;
        logic [20:0] cp;
        t_octet_q    text;
        roll = $urandom_range(0, 19);
        kind = (roll < 5)  ? FRAG_ASCII :
               (roll < 8)  ? FRAG_TWO :
               (roll < 11) ? FRAG_THREE :
               (roll < 14) ? FRAG_FOUR :
               (roll == 14) ? FRAG_SURROGATE :
               (roll == 15) ? FRAG_OVERLONG :
               (roll == 16) ? FRAG_TOO_BIG :
               (roll == 17) ? FRAG_TRUNCATED :
               (roll == 18) ? FRAG_NOISE : FRAG_STRAY_CONT;
        case (kind)
            FRAG_ASCII:     text = utf8_encode(21'($urandom_range(0, 'h7F)), 3'd1);
            FRAG_TWO:       text = utf8_encode(21'($urandom_range('h80, 'h7FF)), SEQ_TWO);
            FRAG_THREE:     text = utf8_encode(21'($urandom_range('h800, 'hFFFF)), SEQ_THREE);
            FRAG_FOUR:      text = utf8_encode(21'($urandom_range('h10000, 'h10FFFF)),
                                               SEQ_FOUR);
            FRAG_SURROGATE: text = utf8_encode(21'($urandom_range('hD800, 'hDFFF)), SEQ_THREE);
            FRAG_OVERLONG: begin
                len  = 3'($urandom_range(2, 4));
                cp   = (len == SEQ_TWO)   ? 21'($urandom_range(0, 'h7F)) :
                       (len == SEQ_THREE) ? 21'($urandom_range(0, 'h7FF)) :
                                            21'($urandom_range(0, 'hFFFF));
                text = utf8_encode(cp, len);
            end
            FRAG_TOO_BIG:   text = utf8_encode(21'($urandom_range('h110000, 'h1FFFFF)),
                                               SEQ_FOUR);
            FRAG_TRUNCATED: begin
                len  = 3'($urandom_range(2, 4));
                text = utf8_encode(21'($urandom_range('h80, 'h10FFFF)), len);
                cut  = $urandom_range(1, int'(len) - 1);
                text = text[0:cut - 1];
            end
            FRAG_NOISE:     text = '{8'($urandom_range(0, 255))};
            default:        text = '{{CONT_TAG, 6'($urandom_range(0, 63))}};
        endcase
        send_text(text, $urandom_range(0, 7) == 0);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    task automatic test_single_byte();
        send_text('{8'h00}, 1'b0);
        send_text('{8'h7F}, 1'b1);
    endtask

    // Smallest two- and three-byte values, both ends of the surrogate pair range
    task automatic test_valid_sequences();
        send_text('{8'hC2, 8'h80}, 1'b0);
        send_text('{8'hE0, 8'hA0, 8'h80}, 1'b0);
        send_text('{8'hF0, 8'h90, 8'h80, 8'h80}, 1'b0);
        send_text('{8'hF4, 8'h8F, 8'hBF, 8'hBF}, 1'b1);
    endtask

    // Surrogate code point, overlong form, value above U+10FFFF
    task automatic test_bad_values();
        send_text('{8'hED, 8'hA0, 8'h80}, 1'b0);
        send_text('{8'hE0, 8'h9F, 8'hBF}, 1'b0);
        send_text('{8'hF4, 8'h90, 8'h80, 8'h80}, 1'b1);
    endtask

    task automatic test_invalid_leads();
        send_text('{8'h80, 8'hFF}, 1'b0);
    endtask

    // Open sequence broken by a plain byte, then one cut off by the string end
    task automatic test_broken_and_cut_off();
        send_text('{8'hF0, 8'h90, 8'h80, 8'h41}, 1'b0);
        send_text('{8'hE0, 8'hA0}, 1'b1);
    endtask

    task automatic test_random_text();
        while (bytes_accepted < ITEM_TARGET - TAIL_ITEMS) send_random_fragment();
    endtask

    // Full rate on both sides
    task automatic test_back_to_back();
        src_gaps_on    = 1'b0;
        sink_stalls_on = 1'b0;
        while (bytes_accepted < ITEM_TARGET) send_random_fragment();
    endtask

    // ---------------------------------------------------------------
    // Sequence of tests
    // ---------------------------------------------------------------
    initial begin
        i_rst_n        <= 1'b0;
        s_tvalid       <= 1'b0;
        s_tdata        <= '0;
        s_tlast        <= 1'b0;
        cp_acc          = '0;
        seq_len         = SEQ_NONE;
        seq_taken       = '0;
        src_gaps_on     = 1'b1;
        sink_stalls_on  = 1'b1;
        n_fail          = 0;
        bytes_accepted  = 0;
        strings_ended   = 0;
        units_checked   = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_byte();
        test_valid_sequences();
        test_bad_values();
        test_invalid_leads();
        test_broken_and_cut_off();
        test_random_text();
        test_back_to_back();

        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        while (expected_units.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("decoded %0d UTF-8 bytes (%0d strings ended) into %0d checked UTF-16 units",
                 bytes_accepted, strings_ended, units_checked);
        $display("stimulus: valid 1-4 byte forms, bad values, invalid leads, broken and cut-off");
        if (n_fail == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", n_fail);
            $display("status: fail");
        end
        $finish;
    end

endmodule
